>>> rtl/integer_to_ascii_formatter_macros.svh
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Concurrent check wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication
`define ITAF_ASSERT_IMP(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itaf check failed");
// Next-cycle implication
`define ITAF_ASSERT_NXT(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itaf check failed");
`else
`define ITAF_ASSERT_IMP(lbl, clock, rstn, ante, cons)
`define ITAF_ASSERT_NXT(lbl, clock, rstn, ante, cons)
`endif

`endif

>>> rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, control-word layout and constants of the ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itaf_pkg;

    // Format commands
    typedef enum logic [1:0] {
        CMD_SDEC  = 2'd0,
        CMD_UDEC  = 2'd1,
        CMD_HEX32 = 2'd2,
        CMD_PTR   = 2'd3
    } cmd_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_DIV10,
        OP_HEX,
        OP_EMIT
    } dp_op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_HEX,
        C_MORE_DIV,
        C_MORE_HEX,
        C_NOT_LAST
    } cond_t;

    // Output stage use
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_IF_NEG,
        OUT_DIGIT
    } out_use_t;

    typedef logic [2:0] step_t;

    // Program addresses
    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_SIGN  = 3'd1;
    localparam step_t STEP_MUL   = 3'd2;
    localparam step_t STEP_DIV   = 3'd3;
    localparam step_t STEP_JDIG  = 3'd4;
    localparam step_t STEP_HEX   = 3'd5;
    localparam step_t STEP_DIGIT = 3'd6;
    localparam step_t STEP_JWAIT = 3'd7;

    typedef struct packed {
        dp_op_t   op;
        cond_t    cond;
        out_use_t out_use;
        step_t    target;
    } ucode_word_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic hex;
        logic neg;
        logic more_div;
        logic more_hex;
        logic last_digit;
    } dp_status_t;

    // Reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit x
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [4:0]  MAX_CHARS   = 5'd16;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = 8'h30 + {4'd0, d};
            else if (upper)
                c = 8'h37 + {4'd0, d};
            else
                c = 8'h57 + {4'd0, d};
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/itaf_ucode_rom.sv
// ----------------------------------------------------------------------------
// itaf_ucode_rom
// Control store: one control word per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_ucode_rom
    import itaf_pkg::*;
(
    input  wire step_t       step,
    output ucode_word_t      cw
);

    // Jump taken when cond holds, otherwise fall through to step + 1.
    always_comb
    begin
        case (step)
            STEP_WAIT:  cw = '{op: OP_LOAD,  cond: C_NO_ACCEPT, out_use: OUT_NONE,
                               target: STEP_WAIT};
            STEP_SIGN:  cw = '{op: OP_NOP,   cond: C_HEX,       out_use: OUT_IF_NEG,
                               target: STEP_HEX};
            STEP_MUL:   cw = '{op: OP_MUL,   cond: C_NEVER,     out_use: OUT_NONE,
                               target: STEP_WAIT};
            STEP_DIV:   cw = '{op: OP_DIV10, cond: C_MORE_DIV,  out_use: OUT_NONE,
                               target: STEP_MUL};
            STEP_JDIG:  cw = '{op: OP_NOP,   cond: C_ALWAYS,    out_use: OUT_NONE,
                               target: STEP_DIGIT};
            STEP_HEX:   cw = '{op: OP_HEX,   cond: C_MORE_HEX,  out_use: OUT_NONE,
                               target: STEP_HEX};
            STEP_DIGIT: cw = '{op: OP_EMIT,  cond: C_NOT_LAST,  out_use: OUT_DIGIT,
                               target: STEP_DIGIT};
            STEP_JWAIT: cw = '{op: OP_NOP,   cond: C_ALWAYS,    out_use: OUT_NONE,
                               target: STEP_WAIT};
            default:    cw = '{op: OP_NOP,   cond: C_ALWAYS,    out_use: OUT_NONE,
                               target: STEP_WAIT};
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/itaf_datapath.sv
// ----------------------------------------------------------------------------
// itaf_datapath
// Magnitude register, reciprocal multiplier, digit buffer and digit count.
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_datapath
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire dp_op_t       op,
    input  wire               en,
    input  wire [1:0]         cmd,
    input  wire [63:0]        value,
    input  wire               upper_case,
    output dp_status_t        status,
    output logic [7:0]        digit_char
);

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [63:0]            prod_reg;
    logic [3:0]             buf_reg [16];
    logic [4:0]             nd_reg, nd_next;
    logic                   hex_reg, neg_reg, upper_reg;

    logic [28:0]            quot;
    logic [31:0]            quot_x10;
    logic [31:0]            rem32;
    logic [4:0]             nd_m1;
    logic [31:0]            neg_low;

    assign quot     = prod_reg[63:RECIP_SHIFT];
    assign quot_x10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
    assign rem32    = mag_reg[31:0] - quot_x10;
    assign nd_m1    = nd_reg - 5'd1;
    assign neg_low  = ~value[31:0] + 32'd1;

    always_comb
    begin
        mag_next = mag_reg;
        nd_next  = nd_reg;
        case (op)
            OP_LOAD:
            begin
                nd_next = 5'd0;
                case (cmd_t'(cmd))
                    CMD_SDEC:  mag_next = value[31] ? VALUE_WIDTH'(neg_low)
                                                    : VALUE_WIDTH'(value[31:0]);
                    CMD_UDEC,
                    CMD_HEX32: mag_next = VALUE_WIDTH'(value[31:0]);
                    default:   mag_next = value[VALUE_WIDTH-1:0];
                endcase
            end
            OP_DIV10:
            begin
                mag_next = VALUE_WIDTH'(quot);
                nd_next  = nd_reg + 5'd1;
            end
            OP_HEX:
            begin
                mag_next = mag_reg >> 4;
                nd_next  = nd_reg + 5'd1;
            end
            OP_EMIT:   nd_next = nd_m1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg    <= 5'd0;
            hex_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            upper_reg <= 1'b0;
        end
        else if (en)
        begin
            nd_reg <= nd_next;
            if (op == OP_LOAD)
            begin
                hex_reg   <= cmd[1];
                neg_reg   <= (cmd_t'(cmd) == CMD_SDEC) && value[31];
                upper_reg <= (cmd_t'(cmd) == CMD_HEX32) && upper_case;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            if (op == OP_MUL)
                prod_reg <= mag_reg[31:0] * RECIP_TEN;
            if (op == OP_DIV10)
                buf_reg[nd_reg[3:0]] <= rem32[3:0];
            if (op == OP_HEX)
                buf_reg[nd_reg[3:0]] <= mag_reg[3:0];
        end
    end

    assign digit_char        = digit_ascii(buf_reg[nd_m1[3:0]], upper_reg);
    assign status.hex        = hex_reg;
    assign status.neg        = neg_reg;
    assign status.more_div   = (quot != 29'd0);
    assign status.more_hex   = |mag_reg[VALUE_WIDTH-1:4];
    assign status.last_digit = (nd_reg == 5'd1);

endmodule

`default_nettype wire

>>> rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer per input beat as ASCII characters, one per output beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata carries the value, s_axis_tuser the command
//   (signed decimal, unsigned decimal, 32-bit hex, pointer hex) and the
//   upper-case flag. Output stream: one beat per character, most significant
//   first, no leading zeros; m_axis_tlast marks the final character and the
//   running character count rides in m_axis_tdata beside the character.
//   A negative number starts with the minus sign, sent from the sign step
//   that follows the wait step. All digits are formed before the first one
//   is sent (one 32x32 reciprocal multiply and one remainder step per
//   decimal digit, one nibble shift per hex digit). Characters then follow
//   one per cycle while the receiver is ready. A pointer has up to 16 hex
//   digits. A new input beat is taken only in the wait step.
//   Reset puts the sequencer in its wait step with the output register empty.
//   A receiver stall holds the output register; the sequencer waits in the
//   emitting step until the register frees, so no character is lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [63:0] value
    input  wire  [2:0]  s_axis_tuser,   // [1:0] cmd, [2] upper_case
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [12:8] char_count, rest 0
    output logic        m_axis_tlast
);

    step_t       step_reg, step_next;
    ucode_word_t cw;
    dp_status_t  st;
    logic [7:0]  digit_char;

    logic        accept;
    logic        out_free;
    logic        need_out;
    logic        hold;
    logic        emit;
    logic        cond_true;
    logic        dp_en;

    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;

    itaf_ucode_rom u_rom
    (
        .step (step_reg),
        .cw   (cw)
    );

    itaf_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (cw.op),
        .en         (dp_en),
        .cmd        (s_axis_tuser[1:0]),
        .value      (s_axis_tdata),
        .upper_case (s_axis_tuser[2]),
        .status     (st),
        .digit_char (digit_char)
    );

    // Handshake: input only in the load step
    assign s_axis_tready = (cw.op == OP_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Output register frees when empty or being taken this cycle
    assign out_free = !valid_reg || m_axis_tready;
    assign need_out = (cw.out_use == OUT_DIGIT) || ((cw.out_use == OUT_IF_NEG) && st.neg);
    assign hold     = need_out && !out_free;
    assign emit     = need_out && out_free;
    assign dp_en    = (cw.op == OP_LOAD) ? accept : !hold;

    always_comb
    begin
        case (cw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_ACCEPT: cond_true = !accept;
            C_HEX:       cond_true = st.hex;
            C_MORE_DIV:  cond_true = st.more_div;
            C_MORE_HEX:  cond_true = st.more_hex;
            C_NOT_LAST:  cond_true = !st.last_digit;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
            step_next = step_reg;
        else if (cond_true)
            step_next = cw.target;
        else
            step_next = step_reg + 3'd1;
    end

    // Output stage; the count restarts at one on the beat after a final
    // character, so a waiting beat never sees its count change
    always_comb
    begin
        cnt_next   = cnt_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_axis_tready;
        if (emit)
        begin
            cnt_next   = last_reg ? 5'd1 : cnt_reg + 5'd1;
            valid_next = 1'b1;
            if (cw.out_use == OUT_DIGIT)
            begin
                char_next = digit_char;
                last_next = st.last_digit;
            end
            else
            begin
                char_next = CHAR_MINUS;
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_WAIT;
            cnt_reg   <= 5'd0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {3'b000, cnt_reg, char_reg};

    // Checks
    `ITAF_ASSERT_NXT(a_load_to_sign, clk, rst_n, accept, step_reg == STEP_SIGN)
    `ITAF_ASSERT_IMP(a_count_range, clk, rst_n, valid_reg, (cnt_reg != 5'd0) && (cnt_reg <= MAX_CHARS))
    `ITAF_ASSERT_IMP(a_emit_has_digit, clk, rst_n, (step_reg == STEP_DIGIT) && emit, last_reg || (cnt_reg < MAX_CHARS))

endmodule

`default_nettype wire
